FILE: design/trimmed_mean_pot_filter_macros.svh
// assertion macros for the trimmed mean pot filter
// used by the top level, which provides clk and rst_n in scope
`ifndef TRIMMED_MEAN_POT_FILTER_MACROS_SVH
`define TRIMMED_MEAN_POT_FILTER_MACROS_SVH
`ifndef SYNTH
// check that holds outside reset
`define TMPF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds across reset
`define TMPF_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMPF_ASSERT(name, prop, msg)
`define TMPF_ASSERT_RST(name, prop, msg)
`endif
`endif

FILE: design/tmpf_pkg.sv
// shared constants, widths and the arithmetic unit control type
// for the trimmed mean pot filter; no dependencies
package tmpf_pkg;

  localparam int SAMPLE_COUNT   = 10;
  localparam int TRIM_EACH_SIDE = 2;
  localparam int KEPT           = SAMPLE_COUNT - 2 * TRIM_EACH_SIDE;
  localparam bit HAS_KEPT       = (KEPT > 0);
  localparam int AVG_DIV        = HAS_KEPT ? KEPT : 1;

  localparam int MV_W  = 12;
  localparam int PCT_W = 7;
  localparam int IDX_W = $clog2(SAMPLE_COUNT);

  localparam int FULL_SCALE = 3300;
  localparam int PCT_SCALE  = 100;
  localparam logic [MV_W-1:0] FULL_SCALE_MV = MV_W'(FULL_SCALE);

  // working width covers level * 100 and the burst sum
  localparam int ACC_W   = $clog2(FULL_SCALE * PCT_SCALE + 1);
  localparam int RECIP_W = ACC_W + 1;
  localparam int PROD_W  = ACC_W + RECIP_W;

  // floor reciprocals scaled by 2^ACC_W, quotient is low by at most one
  localparam logic [RECIP_W-1:0] RECIP_AVG = RECIP_W'((1 << ACC_W) / AVG_DIV);
  localparam logic [RECIP_W-1:0] RECIP_PCT = RECIP_W'((1 << ACC_W) / FULL_SCALE);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);
  localparam logic [IDX_W-1:0] SUM_FIRST = IDX_W'(TRIM_EACH_SIDE);
  localparam logic [IDX_W-1:0] SUM_LAST =
    HAS_KEPT ? IDX_W'(SAMPLE_COUNT - TRIM_EACH_SIDE - 1) : IDX_W'(0);

  // arithmetic unit operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_CMP   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
  localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
  localparam logic [OP_W-1:0] OP_RMUL  = 3'd4;
  localparam logic [OP_W-1:0] OP_FIX   = 3'd5;

  // divisor select
  localparam logic DSEL_AVG = 1'b0;
  localparam logic DSEL_PCT = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            dsel;
  } alu_ctl_t;

endpackage

FILE: design/tmpf_store.sv
// sorted sample store: one write port, one registered read port that
// passes a same-cycle write through; depends on tmpf_pkg
module tmpf_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [tmpf_pkg::IDX_W-1:0] wr_idx,
  input  logic [tmpf_pkg::MV_W-1:0]  wr_data,
  input  logic [tmpf_pkg::IDX_W-1:0] rd_idx,
  output logic [tmpf_pkg::MV_W-1:0]  rd_data
);

  logic [tmpf_pkg::MV_W-1:0] mem_r [tmpf_pkg::SAMPLE_COUNT];
  logic [tmpf_pkg::MV_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we && (int'(wr_idx) < tmpf_pkg::SAMPLE_COUNT)) begin
      mem_r[wr_idx] <= wr_data;
    end
    // write-through so an entry written this cycle reads back new
    if (we && (wr_idx == rd_idx)) begin
      rd_data_r <= wr_data;
    end else if (int'(rd_idx) < tmpf_pkg::SAMPLE_COUNT) begin
      rd_data_r <= mem_r[rd_idx];
    end else begin
      rd_data_r <= '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/tmpf_alu.sv
// shared arithmetic unit: compare, add, subtract, scale by 100,
// reciprocal multiply and quotient correction; depends on tmpf_pkg
module tmpf_alu (
  input  tmpf_pkg::alu_ctl_t         ctl,
  input  logic [tmpf_pkg::ACC_W-1:0] a,
  input  logic [tmpf_pkg::ACC_W-1:0] b,
  output logic [tmpf_pkg::ACC_W-1:0] y,
  output logic                       gt
);

  logic [tmpf_pkg::ACC_W-1:0]   div_v;
  logic [tmpf_pkg::RECIP_W-1:0] recip_v;
  logic [tmpf_pkg::PROD_W-1:0]  rm_prod;
  logic [2*tmpf_pkg::ACC_W-1:0] back_full;
  logic [tmpf_pkg::ACC_W-1:0]   rem;
  logic [tmpf_pkg::ACC_W+6:0]   scale_full;

  always_comb begin
    div_v   = (ctl.dsel == tmpf_pkg::DSEL_PCT) ? tmpf_pkg::ACC_W'(tmpf_pkg::FULL_SCALE)
                                               : tmpf_pkg::ACC_W'(tmpf_pkg::AVG_DIV);
    recip_v = (ctl.dsel == tmpf_pkg::DSEL_PCT) ? tmpf_pkg::RECIP_PCT : tmpf_pkg::RECIP_AVG;
    rm_prod    = tmpf_pkg::PROD_W'(a) * tmpf_pkg::PROD_W'(recip_v);
    // b holds the estimated quotient for the correction step
    back_full  = (2*tmpf_pkg::ACC_W)'(b) * (2*tmpf_pkg::ACC_W)'(div_v);
    rem        = a - back_full[tmpf_pkg::ACC_W-1:0];
    scale_full = (tmpf_pkg::ACC_W+7)'(a) * (tmpf_pkg::ACC_W+7)'(tmpf_pkg::PCT_SCALE);
    gt = (a > b);
    unique case (ctl.op)
      tmpf_pkg::OP_CMP:   y = '0;
      tmpf_pkg::OP_ADD:   y = a + b;
      tmpf_pkg::OP_SUB:   y = a - b;
      tmpf_pkg::OP_SCALE: y = scale_full[tmpf_pkg::ACC_W-1:0];
      tmpf_pkg::OP_RMUL:  y = rm_prod[2*tmpf_pkg::ACC_W-1:tmpf_pkg::ACC_W];
      tmpf_pkg::OP_FIX:   y = b + tmpf_pkg::ACC_W'(rem >= div_v);
      default:            y = '0;
    endcase
  end

endmodule

FILE: design/trimmed_mean_pot_filter.sv
// Trimmed mean pot filter top level: sequencer, sorted store and shared unit.
// Takes each sample word (clamped to 3300 mV) into a ten-entry store kept in
// ascending order by insertion, one compare and shift per cycle in the shared
// arithmetic unit. Each sample is latched, shifted past every larger entry and
// then written into its slot; in_stall is high while it is inserted.
// The store read port is registered, so each cycle sets up the entry that the
// next cycle compares or adds.
// The tenth sample of a burst also runs the tail: the middle entries are summed
// through the store read port, then the same unit multiplies, corrects, inverts,
// scales, multiplies and corrects, and the result word is loaded once the
// previous result word has been taken. One result word (level_mv, level_percent)
// comes out per burst; then a new burst starts.
// Depends on tmpf_pkg, tmpf_store, tmpf_alu and the assertion macro header.
`include "trimmed_mean_pot_filter_macros.svh"

module trimmed_mean_pot_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tmpf_pkg::MV_W-1:0]       in_sample_mv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tmpf_pkg::MV_W-1:0]       out_level_mv,
  output logic [tmpf_pkg::PCT_W-1:0]      out_level_percent
);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS     = 4'd1;
  localparam logic [3:0] S_SUM     = 4'd2;
  localparam logic [3:0] S_AVG_MUL = 4'd3;
  localparam logic [3:0] S_AVG_FIX = 4'd4;
  localparam logic [3:0] S_LEVEL   = 4'd5;
  localparam logic [3:0] S_SCALE   = 4'd6;
  localparam logic [3:0] S_PCT_MUL = 4'd7;
  localparam logic [3:0] S_PCT_FIX = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0]                  state_r, state_nxt;
  logic [tmpf_pkg::IDX_W-1:0]  cnt_r, cnt_nxt;      // samples in this burst
  logic [tmpf_pkg::IDX_W-1:0]  pos_r, pos_nxt;      // insertion slot
  logic [tmpf_pkg::IDX_W-1:0]  idx_r, idx_nxt;      // sum walk index
  logic [tmpf_pkg::MV_W-1:0]   v_r, v_nxt;          // clamped sample
  logic [tmpf_pkg::ACC_W-1:0]  acc_r, acc_nxt;      // sum, then scaled level
  logic [tmpf_pkg::ACC_W-1:0]  q_r, q_nxt;          // quotient
  logic [tmpf_pkg::MV_W-1:0]   lvl_r, lvl_nxt;      // inverted mean
  logic                        out_valid_r, out_valid_nxt;
  logic [tmpf_pkg::MV_W-1:0]   out_mv_r, out_mv_nxt;
  logic [tmpf_pkg::PCT_W-1:0]  out_pct_r, out_pct_nxt;

  // store port
  logic                        st_we;
  logic [tmpf_pkg::IDX_W-1:0]  st_wr_idx;
  logic [tmpf_pkg::MV_W-1:0]   st_wr_data;
  logic [tmpf_pkg::IDX_W-1:0]  st_rd_idx;
  logic [tmpf_pkg::MV_W-1:0]   st_rd_data;

  // shared unit
  tmpf_pkg::alu_ctl_t          alu_ctl;
  logic [tmpf_pkg::ACC_W-1:0]  alu_a, alu_b, alu_y;
  logic                        alu_gt;

  logic [tmpf_pkg::MV_W-1:0]   smp_clamped;
  logic                        do_shift;

  tmpf_store u_store (
    .clk     (clk),
    .we      (st_we),
    .wr_idx  (st_wr_idx),
    .wr_data (st_wr_data),
    .rd_idx  (st_rd_idx),
    .rd_data (st_rd_data)
  );

  tmpf_alu u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y),
    .gt  (alu_gt)
  );

  // oversized samples count as full scale
  assign smp_clamped = (in_sample_mv > tmpf_pkg::FULL_SCALE_MV) ? tmpf_pkg::FULL_SCALE_MV
                                                                : in_sample_mv;

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_level_mv      = out_mv_r;
  assign out_level_percent = out_pct_r;

  // a larger entry below the slot moves up one; equal entries stay below
  assign do_shift = (pos_r != '0) && alu_gt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    v_nxt         = v_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    lvl_nxt       = lvl_r;
    out_mv_nxt    = out_mv_r;
    out_pct_nxt   = out_pct_r;
    out_valid_nxt = out_valid_r;
    st_we         = 1'b0;
    st_wr_idx     = pos_r;
    st_wr_data    = v_r;
    // while idle, fetch the top filled entry for the first compare
    st_rd_idx     = cnt_r - tmpf_pkg::IDX_W'(1);
    alu_ctl.op    = tmpf_pkg::OP_CMP;
    alu_ctl.dsel  = tmpf_pkg::DSEL_AVG;
    alu_a         = tmpf_pkg::ACC_W'(st_rd_data);
    alu_b         = tmpf_pkg::ACC_W'(v_r);

    // result word taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt     = smp_clamped;
          pos_nxt   = cnt_r;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        st_we = 1'b1;
        if (do_shift) begin
          st_wr_data = st_rd_data;
          pos_nxt    = pos_r - tmpf_pkg::IDX_W'(1);
          // entry below the next slot for the following compare
          st_rd_idx  = pos_r - tmpf_pkg::IDX_W'(2);
        end else if (cnt_r == tmpf_pkg::LAST_IDX) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          idx_nxt   = tmpf_pkg::SUM_FIRST;
          st_rd_idx = tmpf_pkg::SUM_FIRST;
          if (tmpf_pkg::HAS_KEPT) begin
            state_nxt = S_SUM;
          end else begin
            // nothing left after trimming: mean is zero
            q_nxt     = '0;
            state_nxt = S_LEVEL;
          end
        end else begin
          cnt_nxt   = cnt_r + tmpf_pkg::IDX_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        st_rd_idx  = idx_r + tmpf_pkg::IDX_W'(1);
        alu_ctl.op = tmpf_pkg::OP_ADD;
        alu_a      = acc_r;
        alu_b      = tmpf_pkg::ACC_W'(st_rd_data);
        acc_nxt    = alu_y;
        if (idx_r == tmpf_pkg::SUM_LAST) begin
          state_nxt = S_AVG_MUL;
        end else begin
          idx_nxt = idx_r + tmpf_pkg::IDX_W'(1);
        end
      end
      S_AVG_MUL: begin
        alu_ctl.op = tmpf_pkg::OP_RMUL;
        alu_a      = acc_r;
        q_nxt      = alu_y;
        state_nxt  = S_AVG_FIX;
      end
      S_AVG_FIX: begin
        alu_ctl.op = tmpf_pkg::OP_FIX;
        alu_a      = acc_r;
        alu_b      = q_r;
        q_nxt      = alu_y;
        state_nxt  = S_LEVEL;
      end
      S_LEVEL: begin
        alu_ctl.op = tmpf_pkg::OP_SUB;
        alu_a      = tmpf_pkg::ACC_W'(tmpf_pkg::FULL_SCALE_MV);
        alu_b      = q_r;
        lvl_nxt    = alu_y[tmpf_pkg::MV_W-1:0];
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        alu_ctl.op = tmpf_pkg::OP_SCALE;
        alu_a      = tmpf_pkg::ACC_W'(lvl_r);
        acc_nxt    = alu_y;
        state_nxt  = S_PCT_MUL;
      end
      S_PCT_MUL: begin
        alu_ctl.op   = tmpf_pkg::OP_RMUL;
        alu_ctl.dsel = tmpf_pkg::DSEL_PCT;
        alu_a        = acc_r;
        q_nxt        = alu_y;
        state_nxt    = S_PCT_FIX;
      end
      S_PCT_FIX: begin
        alu_ctl.op   = tmpf_pkg::OP_FIX;
        alu_ctl.dsel = tmpf_pkg::DSEL_PCT;
        alu_a        = acc_r;
        alu_b        = q_r;
        q_nxt        = alu_y;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_mv_nxt    = lvl_r;
          out_pct_nxt   = q_r[tmpf_pkg::PCT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    v_r       <= v_nxt;
    acc_r     <= acc_nxt;
    q_r       <= q_nxt;
    lvl_r     <= lvl_nxt;
    out_mv_r  <= out_mv_nxt;
    out_pct_r <= out_pct_nxt;
  end

  `TMPF_ASSERT(a_ins_slot, (state_r == S_INS) |-> (pos_r <= cnt_r), "insert slot beyond fill")
  `TMPF_ASSERT(a_emit_end, (state_r == S_EMIT) |-> (cnt_r == '0), "result before burst end")
  `TMPF_ASSERT(a_out_range, out_valid_r |-> ((out_mv_r <= tmpf_pkg::FULL_SCALE_MV) && (int'(out_pct_r) <= tmpf_pkg::PCT_SCALE)), "result out of range")
  `TMPF_ASSERT(a_emit_load, ((state_r == S_EMIT) && (!out_valid_r || !out_stall)) |=> (out_valid_r && (state_r == S_IDLE)), "result word not loaded")
  `TMPF_ASSERT_RST(a_rst_idle, !rst_n |=> ((state_r == S_IDLE) && !out_valid_r && (cnt_r == '0)), "reset not idle")

endmodule
